@@ rtl/dedup_set_collector_core_assert.svh @@
// assertion macros for the dedup set collector checker
// expects signals named clk and rst in the scope of use
`ifndef DEDUP_SET_COLLECTOR_CORE_ASSERT_SVH
`define DEDUP_SET_COLLECTOR_CORE_ASSERT_SVH

// same-cycle implication, ignored in reset
`define DSC_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dsc check failed");

// next-cycle implication, ignored in reset
`define DSC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dsc check failed");

// next-cycle implication, also checked across reset
`define DSC_ASSERT_NEXT_ALWAYS(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("dsc check failed");

`endif

@@ rtl/dsc_pkg.sv @@
// shared constants and types for the dedup set collector
// no dependencies
package dsc_pkg;

  localparam int VALUE_W      = 31;
  localparam int TDATA_W      = 32;
  localparam int CAPACITY_DEF = 64;

  // result request from the sequencer to the output register
  typedef struct packed {
    logic push;
    logic last;
    logic ovf;
  } emit_t;

endpackage

@@ rtl/dsc_mem.sv @@
// value store: one write port, one registered read port
// depends on dsc_pkg for the value width
module dsc_mem #(
  parameter int DEPTH  = dsc_pkg::CAPACITY_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [dsc_pkg::VALUE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [dsc_pkg::VALUE_W-1:0] rd_data
);

  logic [dsc_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/dsc_seq.sv @@
// sequencer: membership search with one shared comparator, append and list readout
// depends on dsc_pkg and drives the dsc_mem ports
module dsc_seq #(
  parameter int CAPACITY = dsc_pkg::CAPACITY_DEF,
  parameter int ADDR_W   = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dsc_pkg::VALUE_W-1:0] in_value,
  input  logic                        in_finish,
  input  logic                        slot_free,
  output dsc_pkg::emit_t              emit,
  output logic                        wr_en,
  output logic [ADDR_W-1:0]           wr_addr,
  output logic [dsc_pkg::VALUE_W-1:0] wr_data,
  output logic                        rd_en,
  output logic [ADDR_W-1:0]           rd_addr,
  input  logic [dsc_pkg::VALUE_W-1:0] rd_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]                  state, state_next;
  logic [dsc_pkg::VALUE_W-1:0] value, value_next;
  logic [CNT_W-1:0]            count, count_next;
  logic [CNT_W-1:0]            idx, idx_next;
  logic                        q_vld, q_vld_next;
  logic                        q_last, q_last_next;
  logic                        ovf, ovf_next;
  logic                        full;
  logic                        more;
  logic                        push;
  logic                        issue;

  assign full    = (count == CNT_W'(CAPACITY));
  assign more    = (idx < count);
  assign rd_addr = idx[ADDR_W-1:0];
  assign wr_addr = count[ADDR_W-1:0];

  always_comb begin
    state_next  = state;
    value_next  = value;
    count_next  = count;
    idx_next    = idx;
    q_vld_next  = q_vld;
    q_last_next = q_last;
    ovf_next    = ovf;
    in_ready    = 1'b0;
    wr_en       = 1'b0;
    wr_data     = value;
    rd_en       = 1'b0;
    push        = 1'b0;
    issue       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        q_vld_next = 1'b0;
        idx_next   = '0;
        if (in_valid) begin
          if (in_finish) begin
            if (count == '0) begin
              ovf_next = 1'b0;
            end else begin
              state_next = ST_EMIT;
            end
          end else begin
            value_next = in_value;
            if (count == '0) begin
              wr_en      = 1'b1;
              wr_data    = in_value;
              count_next = CNT_W'(1);
            end else begin
              state_next = ST_SEARCH;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (q_vld && (rd_data == value)) begin
          state_next = ST_IDLE;
          q_vld_next = 1'b0;
        end else if (q_vld && q_last) begin
          if (!full) begin
            wr_en      = 1'b1;
            count_next = count + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
          state_next = ST_IDLE;
          q_vld_next = 1'b0;
        end else begin
          issue      = more;
          q_vld_next = more;
        end
      end
      ST_EMIT: begin
        push  = q_vld && slot_free;
        issue = more && (!q_vld || push);
        if (issue) begin
          q_vld_next = 1'b1;
        end else if (push) begin
          q_vld_next = 1'b0;
        end
        if (push && q_last) begin
          count_next = '0;
          ovf_next   = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (issue) begin
      rd_en       = 1'b1;
      idx_next    = idx + 1'b1;
      q_last_next = (idx == count - 1'b1);
    end
  end

  assign emit.push = push;
  assign emit.last = q_last;
  assign emit.ovf  = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      idx    <= '0;
      q_vld  <= 1'b0;
      q_last <= 1'b0;
      ovf    <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      idx    <= idx_next;
      q_vld  <= q_vld_next;
      q_last <= q_last_next;
      ovf    <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

@@ rtl/dedup_set_collector_core.sv @@
// channel  | dir | tdata               | tuser        | tlast
// s_axis   | in  | value [30:0]        | finish       | -
// m_axis   | out | stored_value [30:0] | overflow     | last of list
//
// an offer is compared with the n stored values in turn (written directly if empty, ends early on a match)
// one compare a cycle through the shared comparator against the registered store read
// a finish reads out the n stored values in order, one result a cycle while m_axis_tready stays high
// s_axis_tready is low while a search or a readout runs; the output
// register lets the next item in while the final result waits
// synchronous active-high reset empties the store and clears overflow
// top level; depends on dsc_pkg, dsc_seq and dsc_mem
module dedup_set_collector_core #(
  parameter int CAPACITY = dsc_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dsc_pkg::TDATA_W-1:0] s_axis_tdata,  // value [30:0]
  input  logic                        s_axis_tuser,  // finish
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [dsc_pkg::TDATA_W-1:0] m_axis_tdata,  // stored_value [30:0]
  output logic                        m_axis_tuser,  // overflow
  output logic                        m_axis_tlast
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  dsc_pkg::emit_t              emit;
  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;
  logic [dsc_pkg::VALUE_W-1:0] wr_data;
  logic                        rd_en;
  logic [ADDR_W-1:0]           rd_addr;
  logic [dsc_pkg::VALUE_W-1:0] rd_data;
  logic                        slot_free;
  logic [dsc_pkg::VALUE_W-1:0] out_value;
  logic                        out_last;
  logic                        out_ovf;

  assign slot_free = !m_axis_tvalid || m_axis_tready;

  dsc_seq #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (ADDR_W),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_value  (s_axis_tdata[dsc_pkg::VALUE_W-1:0]),
    .in_finish (s_axis_tuser),
    .slot_free (slot_free),
    .emit      (emit),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  dsc_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit.push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.push) begin
      out_value <= rd_data;
      out_last  <= emit.last;
      out_ovf   <= emit.ovf;
    end
  end

  assign m_axis_tdata = {{(dsc_pkg::TDATA_W - dsc_pkg::VALUE_W){1'b0}}, out_value};
  assign m_axis_tuser = out_ovf;
  assign m_axis_tlast = out_last;

endmodule

@@ rtl/dsc_checker.sv @@
// port-level checks for dedup_set_collector_core, attached by bind
// depends on dsc_pkg and dedup_set_collector_core_assert.svh
`include "dedup_set_collector_core_assert.svh"

module dsc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [dsc_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                        m_axis_tuser,
  input logic                        m_axis_tlast
);

  logic in_take;
  logic out_take;

  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;

  // no result right after reset
  `DSC_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !m_axis_tvalid)

  // input is held off while a list is still being read out
  `DSC_ASSERT_SAME(a_busy_in_list, m_axis_tvalid && !m_axis_tlast, !s_axis_tready && !in_take)

  // overflow flag is the same on every item of one list
  `DSC_ASSERT_NEXT(a_ovf_per_list, out_take && !m_axis_tlast,
                   !m_axis_tvalid || $stable(m_axis_tuser))

  // stalled result holds its data and last flag
  `DSC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind dedup_set_collector_core dsc_checker u_dsc_checker (.*);

@@ tb/tb_dedup_set_collector_core.sv @@
// self-checking testbench for dedup_set_collector_core: directed lists, overflow,
// output stall and random runs, checked against an in-bench model of the set
// depends on dsc_pkg and the dedup_set_collector_core rtl
module tb_dedup_set_collector_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W = dsc_pkg::VALUE_W;
  localparam int TDATA_W = dsc_pkg::TDATA_W;
  localparam int CAP = dsc_pkg::CAPACITY_DEF;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
  localparam int LONG_HOLD = 200;
  localparam int SETTLE = CAP + 8;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               ovf;
  } listed_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;  // value [30:0]
  logic               s_axis_tuser = 1'b0;  // finish
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;  // stored_value [30:0]
  logic               m_axis_tuser;  // overflow
  logic               m_axis_tlast;

  // model of the set and the list it owes on the next finish
  logic [VALUE_W-1:0] held[$];
  logic               held_ovf = 1'b0;
  listed_t            listed_due[$];

  int errors = 0;
  int send_idle_pct = 12;
  int recv_idle_pct = 80;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always #6 clk = ~clk;

  dedup_set_collector_core #(
    .CAPACITY(CAP)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  function void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function void track_item(input logic [VALUE_W-1:0] v, input logic fin);
    listed_t e;
    bit found;
    found = 1'b0;
    if (!fin) begin
      foreach (held[k]) if (held[k] == v) found = 1'b1;
      if (!found) begin
        if (held.size() < CAP) begin
          held.push_back(v);
        end else begin
          held_ovf = 1'b1;
        end
      end
    end else begin
      foreach (held[k]) begin
        e.value = held[k];
        e.last  = (k == held.size() - 1);
        e.ovf   = held_ovf;
        listed_due.push_back(e);
      end
      held.delete();
      held_ovf = 1'b0;
    end
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] r;
    case ($urandom_range(4))
      0, 1: r = VALUE_W'($urandom_range(7));
      2: r = VALUE_W'($urandom);
      3: r = VALUE_W'(1 << $urandom_range(VALUE_W - 1));
      default: r = VALUE_W'(~(1 << $urandom_range(VALUE_W - 1)));
    endcase
    return r;
  endfunction

  // entered at a falling edge, leaves tvalid high at the falling edge after the item
  task send_item(input logic [VALUE_W-1:0] v, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TDATA_W - VALUE_W){1'b0}}, v};
    s_axis_tuser  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    track_item(v, fin);
    @(negedge clk);
  endtask

  task wait_drained;
    s_axis_tvalid <= 1'b0;
    while (listed_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // receiver: random stalls, or a long hold when asked
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    listed_t got;
    listed_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[VALUE_W-1:0], m_axis_tlast, m_axis_tuser};
      if (listed_due.size() == 0) begin
        note_error($sformatf("unexpected item: value %h last %b ovf %b",
                             got.value, got.last, got.ovf));
      end else begin
        want = listed_due.pop_front();
        if (got !== want)
          note_error($sformatf("expected value %h last %b ovf %b, got value %h last %b ovf %b",
                               want.value, want.last, want.ovf,
                               got.value, got.last, got.ovf));
      end
    end
  end

  task test_directed_list;
    send_item('0, 1'b0);
    send_item(VALUE_MAX, 1'b0);
    send_item('0, 1'b0);
    send_item(31'h5555_5555, 1'b0);
    send_item(31'h2aaa_aaaa, 1'b0);
    send_item(VALUE_MAX, 1'b0);
    send_item(31'h0000_1234, 1'b1);
    // finish on an empty store
    send_item(VALUE_MAX, 1'b1);
    send_item(31'h0000_0001, 1'b0);
    send_item('0, 1'b1);
  endtask

  task test_overflow_flag;
    for (int i = 0; i < CAP; i++) send_item(VALUE_W'(VALUE_MAX - i * 3), 1'b0);
    // repeat of a held value while full, then new values dropped
    send_item(VALUE_MAX, 1'b0);
    send_item(31'd5, 1'b0);
    send_item(31'd6, 1'b0);
    send_item('0, 1'b1);
    // flag cleared by the finish
    send_item(31'd5, 1'b0);
    send_item(31'd5, 1'b0);
    send_item('0, 1'b1);
  endtask

  task test_output_stall;
    for (int i = 0; i < 8; i++) send_item(VALUE_W'(1000 + i * 7), 1'b0);
    hold_token++;
    send_item('0, 1'b1);
    for (int i = 0; i < 4; i++) send_item(VALUE_W'(2000 + i), 1'b0);
    send_item('0, 1'b1);
    wait_drained;
  endtask

  task test_random_runs(input int n_items);
    int sent;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) begin
        send_item(random_value(), 1'b1);
        sent++;
      end
      run_len = $urandom_range(12);
      repeat (run_len) begin
        send_item(random_value(), 1'b0);
        sent++;
      end
      send_item(random_value(), 1'b1);
      sent++;
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 12;
    recv_idle_pct = 80;
    test_directed_list;
    test_overflow_flag;
    test_random_runs(2);
    send_idle_pct = 80;
    recv_idle_pct = 12;
    test_output_stall;
    test_random_runs(2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_runs(2);
    wait_drained;
    if (errors == 0) begin
      $display("tb_dedup_set_collector_core: done, clean");
    end else begin
      $display("tb_dedup_set_collector_core: done, errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_dedup_set_collector_core: done, errors");
    $finish;
  end

endmodule

@@ dedup_set_collector_core.f @@
+incdir+rtl
rtl/dsc_pkg.sv
rtl/dsc_mem.sv
rtl/dsc_seq.sv
rtl/dedup_set_collector_core.sv
rtl/dsc_checker.sv
tb/tb_dedup_set_collector_core.sv
